### hdl/xss_pkg.sv
package xss_pkg;

    // word width of the generator state and of every arithmetic operand
    localparam int WORD_W = 64;
    localparam int HALF_W = WORD_W / 2;
    localparam int BIT_CNT_W = $clog2(WORD_W);

    // splitmix64 constants
    localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94d0_49bb_1331_11eb;

    // key XORed with the cycle sample as seed when neither a seed value nor hardware randomness is given
    localparam logic [WORD_W-1:0] FALLBACK_KEY = 64'hdead_beef_badc_0ffe;

    // xoshiro256** step constants
    localparam int XS_SHIFT = 17;
    localparam int XS_ROT   = 45;
    localparam int SS_ROT   = 7;

    // operation codes of an input item
    typedef enum logic [1:0] {
        FUNC_SEED    = 2'd0,
        FUNC_DRAW    = 2'd1,
        FUNC_ENTROPY = 2'd2
    } func_t;

    // sequencer states
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b000_0001,
        ST_ADD   = 7'b000_0010,
        ST_MUL_A = 7'b000_0100,
        ST_MUL_B = 7'b000_1000,
        ST_MUL5  = 7'b001_0000,
        ST_STEP  = 7'b010_0000,
        ST_OUT   = 7'b100_0000
    } state_t;

endpackage

### hdl/xss_if.sv
// input item channel
interface xss_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [63:0] seed_value;
    logic        hw_random_ok;
    logic [63:0] hw_random_value;
    logic [63:0] cycle_sample;
    logic [7:0]  entropy_byte;
    logic        entropy_first;
    logic        entropy_last;
    logic        entropy_empty;

    modport source (
        output valid, func, seed_value, hw_random_ok, hw_random_value,
               cycle_sample, entropy_byte, entropy_first, entropy_last,
               entropy_empty,
        input  ready
    );

    modport sink (
        input  valid, func, seed_value, hw_random_ok, hw_random_value,
               cycle_sample, entropy_byte, entropy_first, entropy_last,
               entropy_empty,
        output ready
    );
endinterface

// result item channel
interface xss_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] random_word;
    logic [31:0] random_high32;

    modport source (
        output valid, random_word, random_high32,
        input  ready
    );

    modport sink (
        input  valid, random_word, random_high32,
        output ready
    );
endinterface

### hdl/xss_smul.sv
module xss_smul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [xss_pkg::WORD_W-1:0] a,
    input  logic [xss_pkg::WORD_W-1:0] b,
    output logic                       done,
    output logic [xss_pkg::WORD_W-1:0] product
);

    logic [xss_pkg::WORD_W-1:0]    a_reg;
    logic [xss_pkg::WORD_W-1:0]    b_reg;
    logic [xss_pkg::WORD_W-1:0]    acc_reg;
    logic [xss_pkg::BIT_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic                          last_bit;

    assign last_bit = (cnt_reg == xss_pkg::BIT_CNT_W'(xss_pkg::WORD_W - 1));

    // control: one multiplier bit per cycle, done pulses after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_bit)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift-and-add datapath, product modulo 2^64
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[xss_pkg::WORD_W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[xss_pkg::WORD_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### hdl/xoshiro256ss_prng_with_seeding_unit.sv
// xoshiro256** generator with splitmix64 seeding and entropy folding.
// req carries one item per transfer: func selects a seed request, a draw or
// an entropy byte. rsp carries one result per draw: random_word is the
// starstar output XOR the item's cycle sample, random_high32 its upper half.
// Seed requests and entropy bytes give no result; a seed request once seeded
// is dropped, as is the unused func code.
// Entropy bytes and ignored items are handled in the idle state. Seeding runs
// four splitmix64 rounds, each an add state and two 64-bit multiplies on a
// shared bit-serial multiplier. A draw on a seeded state passes through the
// MUL5, STEP and OUT states to the output register; a draw on an unseeded
// state runs the seeding first.
// req.ready is high while the sequencer is idle, one item at a time; a
// finished result sits in the output register, so the next item is taken
// while it waits. If rsp stalls with a result still held, the next draw
// waits in its last stage until the register frees up.
// Reset clears the state words, the seeded flag, the entropy accumulator
// and the output valid flag.
module xoshiro256ss_prng_with_seeding_unit (
    input  logic clk,
    input  logic rst_n,
    xss_in_if.sink    req,
    xss_out_if.source rsp
);

    localparam int W = xss_pkg::WORD_W;

    xss_pkg::state_t state_reg;
    logic [W-1:0]    gen_reg [4];
    logic            seeded_reg;
    logic [W-1:0]    acc_reg;
    logic [W-1:0]    walker_reg;
    logic [1:0]      round_reg;
    logic            draw_pend_reg;
    logic [W-1:0]    cyc_reg;
    logic [W-1:0]    m5_reg;
    logic [W-1:0]    res_reg;
    logic            out_valid_reg;
    logic [W-1:0]    out_word_reg;

    logic            accept;
    logic [W-1:0]    zero_seed;
    logic [W-1:0]    seed_sel;
    logic [W-1:0]    walker_add;
    logic            mul_start;
    logic [W-1:0]    mul_a;
    logic [W-1:0]    mul_b;
    logic            mul_done;
    logic [W-1:0]    mul_p;
    logic [W-1:0]    acc_first;
    logic [W-1:0]    acc_fold;
    logic [W-1:0]    rot7;
    logic [W-1:0]    ss_res;
    logic [W-1:0]    t_shift;
    logic [W-1:0]    n0;
    logic [W-1:0]    n1;
    logic [W-1:0]    n2;
    logic [W-1:0]    n3;
    logic            out_free;

    assign req.ready = (state_reg == xss_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // seed choice: given value, else hardware value, else fallback
    assign zero_seed = req.hw_random_ok ? req.hw_random_value
                                        : (req.cycle_sample ^ xss_pkg::FALLBACK_KEY);
    assign seed_sel  = ((req.func == xss_pkg::FUNC_SEED) && (req.seed_value != '0))
                     ? req.seed_value : zero_seed;

    // splitmix64 walker step
    assign walker_add = walker_reg + xss_pkg::GOLDEN_GAMMA;

    // multiplier operands per seeding phase
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = walker_add ^ (walker_add >> 30);
        mul_b     = xss_pkg::MIX_MUL_A;
        if (state_reg == xss_pkg::ST_ADD)
        begin
            mul_start = 1'b1;
        end
        else if ((state_reg == xss_pkg::ST_MUL_A) && mul_done)
        begin
            mul_start = 1'b1;
            mul_a     = mul_p ^ (mul_p >> 27);
            mul_b     = xss_pkg::MIX_MUL_B;
        end
    end

    xss_smul u_smul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // entropy accumulator update
    assign acc_first = req.entropy_first ? req.cycle_sample : acc_reg;
    assign acc_fold  = req.entropy_empty ? acc_first
                     : ({acc_first[W-6:0], 5'b0}
                        ^ {59'b0, acc_first[W-1:W-5]}
                        ^ {56'b0, req.entropy_byte});

    // starstar output from the registered times-five product
    assign rot7   = {m5_reg[W-1-xss_pkg::SS_ROT:0], m5_reg[W-1:W-xss_pkg::SS_ROT]};
    assign ss_res = (rot7 + {rot7[W-4:0], 3'b0}) ^ cyc_reg;

    // xoshiro256 state step
    assign t_shift = gen_reg[1] << xss_pkg::XS_SHIFT;
    assign n2      = gen_reg[2] ^ gen_reg[0];
    assign n3      = gen_reg[3] ^ gen_reg[1];
    assign n1      = gen_reg[1] ^ n2;
    assign n0      = gen_reg[0] ^ n3;

    // sequencer and state words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= xss_pkg::ST_IDLE;
            seeded_reg    <= 1'b0;
            acc_reg       <= '0;
            round_reg     <= '0;
            draw_pend_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                gen_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                xss_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (req.func)
                            xss_pkg::FUNC_SEED:
                            begin
                                if (!seeded_reg)
                                begin
                                    round_reg     <= '0;
                                    draw_pend_reg <= 1'b0;
                                    state_reg     <= xss_pkg::ST_ADD;
                                end
                            end
                            xss_pkg::FUNC_DRAW:
                            begin
                                round_reg     <= '0;
                                draw_pend_reg <= 1'b1;
                                state_reg     <= seeded_reg ? xss_pkg::ST_MUL5
                                                            : xss_pkg::ST_ADD;
                            end
                            xss_pkg::FUNC_ENTROPY:
                            begin
                                acc_reg <= acc_fold;
                                if (req.entropy_last)
                                begin
                                    gen_reg[0] <= gen_reg[0] ^ acc_fold;
                                    gen_reg[1] <= gen_reg[1] ^ req.cycle_sample;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                xss_pkg::ST_ADD:
                begin
                    state_reg <= xss_pkg::ST_MUL_A;
                end
                xss_pkg::ST_MUL_A:
                begin
                    if (mul_done)
                    begin
                        state_reg <= xss_pkg::ST_MUL_B;
                    end
                end
                xss_pkg::ST_MUL_B:
                begin
                    if (mul_done)
                    begin
                        gen_reg[round_reg] <= mul_p ^ (mul_p >> 31);
                        round_reg          <= round_reg + 1'b1;
                        if (round_reg == 2'd3)
                        begin
                            seeded_reg <= 1'b1;
                            state_reg  <= draw_pend_reg ? xss_pkg::ST_MUL5
                                                        : xss_pkg::ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= xss_pkg::ST_ADD;
                        end
                    end
                end
                xss_pkg::ST_MUL5:
                begin
                    state_reg <= xss_pkg::ST_STEP;
                end
                xss_pkg::ST_STEP:
                begin
                    gen_reg[0]    <= n0;
                    gen_reg[1]    <= n1;
                    gen_reg[2]    <= n2 ^ t_shift;
                    gen_reg[3]    <= {n3[W-1-xss_pkg::XS_ROT:0], n3[W-1:W-xss_pkg::XS_ROT]};
                    draw_pend_reg <= 1'b0;
                    state_reg     <= xss_pkg::ST_OUT;
                end
                xss_pkg::ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= xss_pkg::ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= xss_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // item payload and draw datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cyc_reg    <= req.cycle_sample;
            walker_reg <= seed_sel;
        end
        else if (state_reg == xss_pkg::ST_ADD)
        begin
            walker_reg <= walker_add;
        end
        if (state_reg == xss_pkg::ST_MUL5)
        begin
            m5_reg <= gen_reg[1] + {gen_reg[1][W-3:0], 2'b0};
        end
        if (state_reg == xss_pkg::ST_STEP)
        begin
            res_reg <= ss_res;
        end
    end

    // output register, freed by a transfer on rsp
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == xss_pkg::ST_OUT) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == xss_pkg::ST_OUT) && out_free)
        begin
            out_word_reg <= res_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.random_word   = out_word_reg;
    assign rsp.random_high32 = out_word_reg[W-1:xss_pkg::HALF_W];

    // once seeded the generator stays seeded until reset
    a_seeded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        seeded_reg |=> seeded_reg)
        else $error("seeded flag dropped");

    // multiplier finishes only while the sequencer waits on it
    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == xss_pkg::ST_MUL_A || state_reg == xss_pkg::ST_MUL_B))
        else $error("multiplier result outside a multiply phase");

    // a fresh result appears only out of the output stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == xss_pkg::ST_OUT))
        else $error("result loaded outside the output stage");

    // seeding round counter rests at zero outside seeding
    a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (round_reg != 2'd0) |-> (state_reg == xss_pkg::ST_ADD
            || state_reg == xss_pkg::ST_MUL_A || state_reg == xss_pkg::ST_MUL_B))
        else $error("round counter left nonzero");

endmodule

### test/tb_xoshiro256ss_prng_with_seeding_unit.sv
module tb_xoshiro256ss_prng_with_seeding_unit;

    // func code that the block leaves unused
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // items per idling phase, counting draws and entropy bytes only
    localparam int PHASE_ITEMS = 175;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [1:0]  func;
        logic [63:0] seed_value;
        logic        hw_ok;
        logic [63:0] hw_value;
        logic [63:0] cycle;
        logic [7:0]  ebyte;
        logic        efirst;
        logic        elast;
        logic        eempty;
    } req_item_t;

    typedef struct {
        logic [63:0] word;
        logic [31:0] high32;
    } draw_result_t;

    typedef enum int {
        SEED_GIVEN,
        SEED_HW,
        SEED_FALLBACK,
        SEED_BY_DRAW
    } seed_path_t;

    // predictor of the generator state and the draws still owed by the block
    class xoshiro_predictor;
        logic [63:0]  gen[4];
        bit           seeded;
        logic [63:0]  accum;
        draw_result_t pending_draws[$];
        int           mismatches;

        function new();
            foreach (gen[i]) gen[i] = '0;
            seeded = 1'b0;
            accum = '0;
            mismatches = 0;
        endfunction

        function logic [63:0] rotl(logic [63:0] x, int k);
            return (x << k) | (x >> (xss_pkg::WORD_W - k));
        endfunction

        // pick the seed and expand it by splitmix64, only while unseeded
        function void seed_once(logic [63:0] requested, req_item_t it);
            logic [63:0] walker;
            logic [63:0] z;
            if (seeded)
                return;
            walker = requested;
            if (walker == '0)
                walker = it.hw_ok ? it.hw_value : (it.cycle ^ xss_pkg::FALLBACK_KEY);
            for (int i = 0; i < 4; i++)
            begin
                walker += xss_pkg::GOLDEN_GAMMA;
                z = walker;
                z = (z ^ (z >> 30)) * xss_pkg::MIX_MUL_A;
                z = (z ^ (z >> 27)) * xss_pkg::MIX_MUL_B;
                gen[i] = z ^ (z >> 31);
            end
            seeded = 1'b1;
        endfunction

        // starstar output, then one xoshiro256 step
        function logic [63:0] draw_step();
            logic [63:0] res;
            logic [63:0] t;
            res = rotl(gen[1] * 64'd5, xss_pkg::SS_ROT) * 64'd9;
            t = gen[1] << xss_pkg::XS_SHIFT;
            gen[2] ^= gen[0];
            gen[3] ^= gen[1];
            gen[1] ^= gen[2];
            gen[0] ^= gen[3];
            gen[2] ^= t;
            gen[3] = rotl(gen[3], xss_pkg::XS_ROT);
            return res;
        endfunction

        function void accept_item(req_item_t it);
            draw_result_t r;
            case (it.func)
                xss_pkg::FUNC_SEED:
                    seed_once(it.seed_value, it);
                xss_pkg::FUNC_DRAW:
                begin
                    seed_once('0, it);
                    r.word = draw_step() ^ it.cycle;
                    r.high32 = r.word[63:32];
                    pending_draws.push_back(r);
                end
                xss_pkg::FUNC_ENTROPY:
                begin
                    if (it.efirst)
                        accum = it.cycle;
                    if (!it.eempty)
                        accum = (accum << 5) ^ (accum >> 59) ^ {56'd0, it.ebyte};
                    if (it.elast)
                    begin
                        gen[0] ^= accum;
                        gen[1] ^= it.cycle;
                    end
                end
                default:
                    ;
            endcase
        endfunction

        function void check_draw(logic [63:0] word, logic [31:0] high32);
            draw_result_t r;
            if (pending_draws.size() == 0)
            begin
                $error("unexpected result: random_word %h", word);
                mismatches++;
                return;
            end
            r = pending_draws.pop_front();
            if (word !== r.word)
            begin
                $error("random_word: expected %h, got %h", r.word, word);
                mismatches++;
            end
            if (high32 !== r.high32)
            begin
                $error("random_high32: expected %h, got %h", r.high32, high32);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_draws.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;

    xss_in_if  req_if ();
    xss_out_if rsp_if ();

    xoshiro256ss_prng_with_seeding_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    xoshiro_predictor predictor = new();

    // clock
    always #5 clk = ~clk;

    // result side: check each transfer, stall at random
    always @(posedge clk)
    begin
        if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            predictor.check_draw(rsp_if.random_word, rsp_if.random_high32);
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // run limit
    initial
    begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // every field random, func left to the caller
    function automatic req_item_t random_item(logic [1:0] func);
        req_item_t it;
        it.func = func;
        it.seed_value = ($urandom_range(7) == 0) ? '0 : rand64();
        it.hw_ok = 1'($urandom_range(1));
        it.hw_value = rand64();
        it.cycle = rand64();
        it.ebyte = 8'($urandom_range(255));
        it.efirst = 1'($urandom_range(1));
        it.elast = 1'($urandom_range(1));
        it.eempty = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic req_item_t entropy_item(logic [7:0] ebyte, logic efirst,
                                               logic elast, logic eempty);
        req_item_t it;
        it = random_item(xss_pkg::FUNC_ENTROPY);
        it.ebyte = ebyte;
        it.efirst = efirst;
        it.elast = elast;
        it.eempty = eempty;
        return it;
    endfunction

    // drive one item after a random idle gap, return once transferred
    task automatic send_item(req_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.func <= it.func;
        req_if.seed_value <= it.seed_value;
        req_if.hw_random_ok <= it.hw_ok;
        req_if.hw_random_value <= it.hw_value;
        req_if.cycle_sample <= it.cycle;
        req_if.entropy_byte <= it.ebyte;
        req_if.entropy_first <= it.efirst;
        req_if.entropy_last <= it.elast;
        req_if.entropy_empty <= it.eempty;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        predictor.accept_item(it);
    endtask

    // hold the sender until every owed draw has come back
    task automatic wait_for_draws();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (predictor.pending() != 0);
    endtask

    task automatic directed_items();
        req_item_t  it;
        seed_path_t path;
        // entropy acts before seeding too
        it = entropy_item(8'hff, 1'b1, 1'b0, 1'b0);
        it.cycle = '1;
        send_item(it);
        send_item(entropy_item(8'h00, 1'b0, 1'b1, 1'b0));
        it = random_item(FUNC_UNUSED);
        it.seed_value = '1;
        it.cycle = '1;
        send_item(it);
        // the one seeding of the run, by a path chosen at random
        path = seed_path_t'($urandom_range(3));
        it = random_item(xss_pkg::FUNC_SEED);
        case (path)
            SEED_GIVEN:
                it.seed_value = $urandom_range(1) ? '1 : (rand64() | 64'd1);
            SEED_HW:
            begin
                it.seed_value = '0;
                it.hw_ok = 1'b1;
            end
            SEED_FALLBACK:
            begin
                it.seed_value = '0;
                it.hw_ok = 1'b0;
            end
            default:
                it.func = xss_pkg::FUNC_DRAW;
        endcase
        send_item(it);
        // seed requests once seeded are dropped
        it = random_item(xss_pkg::FUNC_SEED);
        it.seed_value = '1;
        send_item(it);
        it = random_item(xss_pkg::FUNC_SEED);
        it.seed_value = '0;
        send_item(it);
        // draws at the cycle sample extremes
        it = random_item(xss_pkg::FUNC_DRAW);
        it.cycle = '0;
        send_item(it);
        it = random_item(xss_pkg::FUNC_DRAW);
        it.cycle = '1;
        send_item(it);
        // empty buffer folds the bare cycle sample
        send_item(entropy_item(8'hff, 1'b1, 1'b1, 1'b1));
        // single byte buffer
        send_item(entropy_item(8'hff, 1'b1, 1'b1, 1'b0));
        send_item(random_item(xss_pkg::FUNC_DRAW));
        // multi byte buffer with an empty middle byte
        send_item(entropy_item(8'h5a, 1'b1, 1'b0, 1'b0));
        send_item(entropy_item(8'ha5, 1'b0, 1'b0, 1'b0));
        send_item(entropy_item(8'h3c, 1'b0, 1'b0, 1'b1));
        send_item(entropy_item(8'h00, 1'b0, 1'b1, 1'b0));
        // bytes with no first mark continue the old accumulator
        send_item(entropy_item(8'h81, 1'b0, 1'b1, 1'b0));
        send_item(random_item(xss_pkg::FUNC_DRAW));
        send_item(random_item(FUNC_UNUSED));
        it = random_item(xss_pkg::FUNC_DRAW);
        it.seed_value = '1;
        send_item(it);
    endtask

    // mostly draws and well-formed entropy buffers, some noise
    task automatic random_items(int target);
        req_item_t it;
        int        counted;
        int        len;
        int        pick;
        counted = 0;
        while (counted < target)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                send_item(random_item(xss_pkg::FUNC_DRAW));
                counted++;
            end
            else if (pick < 80)
            begin
                len = $urandom_range(1, 8);
                for (int b = 0; b < len; b++)
                begin
                    it = entropy_item(8'($urandom_range(255)), b == 0, b == len - 1,
                                      $urandom_range(9) == 0);
                    send_item(it);
                    counted++;
                end
            end
            else if (pick < 90)
            begin
                send_item(random_item(xss_pkg::FUNC_ENTROPY));
                counted++;
            end
            else if (pick < 95)
                send_item(random_item(xss_pkg::FUNC_SEED));
            else
                send_item(random_item(FUNC_UNUSED));
        end
    endtask

    // main sequence
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        req_if.valid = 1'b0;
        req_if.func = xss_pkg::FUNC_SEED;
        req_if.seed_value = '0;
        req_if.hw_random_ok = 1'b0;
        req_if.hw_random_value = '0;
        req_if.cycle_sample = '0;
        req_if.entropy_byte = '0;
        req_if.entropy_first = 1'b0;
        req_if.entropy_last = 1'b0;
        req_if.entropy_empty = 1'b0;
        rsp_if.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();
        wait_for_draws();

        // no idling
        random_items(PHASE_ITEMS);
        wait_for_draws();
        // sender mostly idle
        idle_pct = 82;
        random_items(PHASE_ITEMS);
        wait_for_draws();
        // receiver mostly stalling
        idle_pct = 0;
        stall_pct = 82;
        random_items(PHASE_ITEMS);
        wait_for_draws();
        // both sides
        idle_pct = 31;
        stall_pct = 31;
        random_items(PHASE_ITEMS);
        wait_for_draws();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (predictor.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
